// ----- rtl/tbpe_pkg.sv -----
// Package for the tape byte pulse encoder: byte codes, register indexes,
// reset values, the result word type and the frame builder.
// No dependencies.
package tbpe_pkg;

    localparam logic [7:0]  LEADER_BYTE   = 8'h16;
    localparam logic [7:0]  SYNC_BYTE     = 8'h24;
    localparam int          FRAME_BITS    = 13;
    localparam logic [3:0]  FRAME_COUNT   = 4'd13;
    localparam logic [9:0]  LEADER_RUN_MAX = 10'd1023;
    localparam logic [7:0]  SINCE_SYNC_MAX = 8'd255;

    // Reset values of the configuration registers
    localparam logic [9:0]  LEADER_LENGTH_RST    = 10'd256;
    localparam logic [7:0]  LEADER_MINIMUM_RST   = 8'd2;
    localparam logic [7:0]  GAP_LENGTH_RST       = 8'd20;
    localparam logic [7:0]  HEADER_GAP_AFTER_RST = 8'd9;

    localparam int          CFG_DATA_W = 10;

    typedef enum logic [1:0] {
        REG_LEADER_LENGTH    = 2'd0,
        REG_LEADER_MINIMUM   = 2'd1,
        REG_GAP_LENGTH       = 2'd2,
        REG_HEADER_GAP_AFTER = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic accepted;
        logic line_level;
        logic active;
    } result_t;

    // Frame bits after the start bit: data LSB first, odd parity, four stops
    function automatic logic [FRAME_BITS-1:0] frame_of(input logic [7:0] v);
        frame_of = {4'hF, ~(^v), v};
    endfunction

endpackage

// ----- rtl/tbpe_out_stage.sv -----
// Result register for the tape byte pulse encoder: holds one result word
// until the sink takes it. Depends on tbpe_pkg.
module tbpe_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  tbpe_pkg::result_t load_word,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output tbpe_pkg::result_t out_word
);

    logic              valid_reg;
    tbpe_pkg::result_t word_reg;

    // Room when empty or when the held word leaves in this cycle
    assign room      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= load_word;
        end
    end

endmodule

// ----- rtl/tape_byte_pulse_encoder.sv -----
// Top level of the tape byte pulse encoder: configuration registers, encoder
// state, single-pass step logic. Depends on tbpe_pkg and tbpe_out_stage.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   func, tape_byte
//   out      source     out_valid / out_ready accepted, line_level, active
//   cfg      sink       cfg_wr_en             cfg_index, cfg_data
//
// Each input word is processed in the cycle it is accepted: one clock per
// word unless out_ready stalls, set by the single step of the state update.
// The result word lands in a one-deep output register; a new word is taken
// whenever that register is empty or is being drained in the same cycle.
// A stall on out_ready holds the result and lowers in_ready until it leaves.
// Reset (rst_n low, asynchronous) clears all encoder state and loads the
// configuration defaults; the block takes words right after reset.
module tape_byte_pulse_encoder
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            func,
    input  logic [7:0]                      tape_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            accepted,
    output logic                            line_level,
    output logic                            active,
    input  logic                            cfg_wr_en,
    input  logic [1:0]                      cfg_index,
    input  logic [tbpe_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Configuration
    logic [9:0] leader_length_reg;
    logic [7:0] leader_minimum_reg;
    logic [7:0] gap_length_reg;
    logic [7:0] header_gap_after_reg;

    // Encoder state
    logic        output_level_reg,       output_level_next;
    logic [1:0]  units_left_reg,         units_left_next;
    logic        second_half_reg,        second_half_next;
    logic        bit_value_reg,          bit_value_next;
    logic [12:0] frame_shift_reg,        frame_shift_next;
    logic [3:0]  frame_bits_left_reg,    frame_bits_left_next;
    logic [9:0]  extra_leaders_left_reg, extra_leaders_left_next;
    logic [7:0]  gap_bits_left_reg,      gap_bits_left_next;
    logic [7:0]  hold_value_reg,         hold_value_next;
    logic        hold_full_reg,          hold_full_next;
    logic        hold_wants_gap_reg,     hold_wants_gap_next;
    logic [9:0]  leader_run_reg,         leader_run_next;
    logic [7:0]  since_sync_reg,         since_sync_next;
    logic        gap_done_reg,           gap_done_next;

    logic              step;
    logic              room;
    tbpe_pkg::result_t result;
    tbpe_pkg::result_t out_word;

    assign in_ready = room;
    assign step     = in_valid && room;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leader_length_reg    <= tbpe_pkg::LEADER_LENGTH_RST;
            leader_minimum_reg   <= tbpe_pkg::LEADER_MINIMUM_RST;
            gap_length_reg       <= tbpe_pkg::GAP_LENGTH_RST;
            header_gap_after_reg <= tbpe_pkg::HEADER_GAP_AFTER_RST;
        end
        else if (cfg_wr_en)
        begin
            case (tbpe_pkg::cfg_index_t'(cfg_index))
                tbpe_pkg::REG_LEADER_LENGTH:    leader_length_reg    <= cfg_data[9:0];
                tbpe_pkg::REG_LEADER_MINIMUM:   leader_minimum_reg   <= cfg_data[7:0];
                tbpe_pkg::REG_GAP_LENGTH:       gap_length_reg       <= cfg_data[7:0];
                tbpe_pkg::REG_HEADER_GAP_AFTER: header_gap_after_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // One step of the encoder: a byte offer or one time-unit tick
    always_comb
    begin
        logic       got_bit;
        logic       bit_b;
        logic [1:0] len;
        logic [7:0] offset;

        output_level_next       = output_level_reg;
        units_left_next         = units_left_reg;
        second_half_next        = second_half_reg;
        bit_value_next          = bit_value_reg;
        frame_shift_next        = frame_shift_reg;
        frame_bits_left_next    = frame_bits_left_reg;
        extra_leaders_left_next = extra_leaders_left_reg;
        gap_bits_left_next      = gap_bits_left_reg;
        hold_value_next         = hold_value_reg;
        hold_full_next          = hold_full_reg;
        hold_wants_gap_next     = hold_wants_gap_reg;
        leader_run_next         = leader_run_reg;
        since_sync_next         = since_sync_reg;
        gap_done_next           = gap_done_reg;
        got_bit                 = 1'b0;
        bit_b                   = 1'b0;
        len                     = 2'd0;
        offset                  = since_sync_reg;
        result.accepted         = 1'b0;
        result.active           = 1'b0;

        if (!func)
        begin
            // Byte offer: take it only into an empty holding register
            if (!hold_full_reg)
            begin
                result.accepted     = 1'b1;
                hold_value_next     = tape_byte;
                hold_full_next      = 1'b1;
                hold_wants_gap_next = 1'b0;
                if (tape_byte == tbpe_pkg::LEADER_BYTE)
                begin
                    if (leader_run_reg != tbpe_pkg::LEADER_RUN_MAX)
                    begin
                        leader_run_next = leader_run_reg + 10'd1;
                    end
                end
                else
                begin
                    // A sync after a long enough leader tops the leader up
                    if (tape_byte == tbpe_pkg::SYNC_BYTE &&
                        leader_run_reg > {2'b00, leader_minimum_reg})
                    begin
                        extra_leaders_left_next = (leader_run_reg < leader_length_reg) ?
                            (leader_length_reg - leader_run_reg) : 10'd0;
                        offset          = 8'd0;
                        since_sync_next = 8'd0;
                        gap_done_next   = 1'b0;
                    end
                    leader_run_next = 10'd0;
                end
                if (tape_byte == 8'd0 && !gap_done_next && offset > header_gap_after_reg)
                begin
                    hold_wants_gap_next = 1'b1;
                    gap_done_next       = 1'b1;
                end
                if (since_sync_next != tbpe_pkg::SINCE_SYNC_MAX)
                begin
                    since_sync_next = since_sync_next + 8'd1;
                end
            end
        end
        else
        begin
            if (units_left_reg == 2'd0)
            begin
                if (second_half_reg)
                begin
                    // Second pulse of the bit: short for 1, long for 0
                    second_half_next = 1'b0;
                    len              = bit_value_reg ? 2'd1 : 2'd2;
                end
                else
                begin
                    // Fetch the next bit: frame, gap, extra leader, held byte
                    if (frame_bits_left_reg != 4'd0)
                    begin
                        got_bit              = 1'b1;
                        bit_b                = frame_shift_reg[0];
                        frame_shift_next     = {1'b0, frame_shift_reg[12:1]};
                        frame_bits_left_next = frame_bits_left_reg - 4'd1;
                    end
                    else if (gap_bits_left_reg != 8'd0)
                    begin
                        got_bit            = 1'b1;
                        bit_b              = 1'b1;
                        gap_bits_left_next = gap_bits_left_reg - 8'd1;
                    end
                    else if (extra_leaders_left_reg != 10'd0)
                    begin
                        got_bit                 = 1'b1;
                        extra_leaders_left_next = extra_leaders_left_reg - 10'd1;
                        frame_shift_next        = tbpe_pkg::frame_of(tbpe_pkg::LEADER_BYTE);
                        frame_bits_left_next    = tbpe_pkg::FRAME_COUNT;
                    end
                    else if (hold_full_reg)
                    begin
                        got_bit              = 1'b1;
                        frame_shift_next     = tbpe_pkg::frame_of(hold_value_reg);
                        frame_bits_left_next = tbpe_pkg::FRAME_COUNT;
                        hold_full_next       = 1'b0;
                        gap_bits_left_next   = hold_wants_gap_reg ? gap_length_reg : 8'd0;
                        hold_wants_gap_next  = 1'b0;
                    end
                    if (got_bit)
                    begin
                        bit_value_next   = bit_b;
                        second_half_next = 1'b1;
                        len              = 2'd1;
                    end
                end
                if (len != 2'd0)
                begin
                    output_level_next = ~output_level_reg;
                end
                units_left_next = len;
            end
            if (units_left_next != 2'd0)
            begin
                units_left_next = units_left_next - 2'd1;
                result.active   = 1'b1;
            end
        end

        result.line_level = output_level_next;
    end

    // Advance the state on every accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_level_reg       <= 1'b0;
            units_left_reg         <= 2'd0;
            second_half_reg        <= 1'b0;
            bit_value_reg          <= 1'b0;
            frame_shift_reg        <= 13'd0;
            frame_bits_left_reg    <= 4'd0;
            extra_leaders_left_reg <= 10'd0;
            gap_bits_left_reg      <= 8'd0;
            hold_value_reg         <= 8'd0;
            hold_full_reg          <= 1'b0;
            hold_wants_gap_reg     <= 1'b0;
            leader_run_reg         <= 10'd0;
            since_sync_reg         <= 8'd0;
            gap_done_reg           <= 1'b0;
        end
        else if (step)
        begin
            output_level_reg       <= output_level_next;
            units_left_reg         <= units_left_next;
            second_half_reg        <= second_half_next;
            bit_value_reg          <= bit_value_next;
            frame_shift_reg        <= frame_shift_next;
            frame_bits_left_reg    <= frame_bits_left_next;
            extra_leaders_left_reg <= extra_leaders_left_next;
            gap_bits_left_reg      <= gap_bits_left_next;
            hold_value_reg         <= hold_value_next;
            hold_full_reg          <= hold_full_next;
            hold_wants_gap_reg     <= hold_wants_gap_next;
            leader_run_reg         <= leader_run_next;
            since_sync_reg         <= since_sync_next;
            gap_done_reg           <= gap_done_next;
        end
    end

    // Hold the result word until the sink takes it
    tbpe_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .load_word (result),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    assign accepted   = out_word.accepted;
    assign line_level = out_word.line_level;
    assign active     = out_word.active;

endmodule
